// ===== design/yrgb_pkg.sv =====
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared widths, register indexes, reset values and stage payload types for
// the YUYV to RGB888 converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

	localparam int PIX_W      = 8;
	localparam int CHROMA_W   = PIX_W + 1;
	localparam int COEF_W     = 10;
	localparam int OFFSET_W   = 9;
	localparam int PROD_W     = COEF_W + CHROMA_W;
	localparam int SUM_W      = PROD_W + 1;
	localparam int PIX_SUM_W  = SUM_W + 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = COEF_W;

	localparam int DEF_COEF_FRAC_BITS = 8;

	localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;
	localparam logic [PIX_W-1:0] CHROMA_MID = 8'd128;

	localparam logic signed [OFFSET_W-1:0] RST_OFFSET      = 9'sd0;
	localparam logic        [COEF_W-1:0]   RST_COEF_V_TO_R = 10'd359;
	localparam logic        [COEF_W-1:0]   RST_COEF_U_TO_G = 10'd88;
	localparam logic        [COEF_W-1:0]   RST_COEF_V_TO_G = 10'd183;
	localparam logic        [COEF_W-1:0]   RST_COEF_U_TO_B = 10'd454;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OFFSET_RED   = 3'd0,
		REG_OFFSET_GREEN = 3'd1,
		REG_OFFSET_BLUE  = 3'd2,
		REG_COEF_V_TO_R  = 3'd3,
		REG_COEF_U_TO_G  = 3'd4,
		REG_COEF_V_TO_G  = 3'd5,
		REG_COEF_U_TO_B  = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic signed [OFFSET_W-1:0] offset_red;
		logic signed [OFFSET_W-1:0] offset_green;
		logic signed [OFFSET_W-1:0] offset_blue;
		logic        [COEF_W-1:0]   coef_v_to_r;
		logic        [COEF_W-1:0]   coef_u_to_g;
		logic        [COEF_W-1:0]   coef_v_to_g;
		logic        [COEF_W-1:0]   coef_u_to_b;
	} cfg_regs_t;

	typedef struct packed {
		logic [PIX_W-1:0] luma_first;
		logic [PIX_W-1:0] chroma_blue;
		logic [PIX_W-1:0] luma_second;
		logic [PIX_W-1:0] chroma_red;
		logic             frame_end;
	} yuyv_t;

	typedef struct packed {
		logic [PIX_W-1:0]         luma_first;
		logic [PIX_W-1:0]         luma_second;
		logic                     frame_end;
		logic signed [PROD_W-1:0] prod_v_to_r;
		logic signed [PROD_W-1:0] prod_u_to_g;
		logic signed [PROD_W-1:0] prod_v_to_g;
		logic signed [PROD_W-1:0] prod_u_to_b;
	} prod_t;

	typedef struct packed {
		logic [PIX_W-1:0]        luma_first;
		logic [PIX_W-1:0]        luma_second;
		logic                    frame_end;
		logic signed [SUM_W-1:0] term_red;
		logic signed [SUM_W-1:0] term_green;
		logic signed [SUM_W-1:0] term_blue;
	} term_t;

	typedef struct packed {
		logic [PIX_W-1:0] red_first;
		logic [PIX_W-1:0] green_first;
		logic [PIX_W-1:0] blue_first;
		logic [PIX_W-1:0] red_second;
		logic [PIX_W-1:0] green_second;
		logic [PIX_W-1:0] blue_second;
		logic             frame_end;
	} rgb_pair_t;

endpackage

// ===== design/yrgb_ifs.sv =====
// ----------------------------------------------------------------------------
// yrgb interfaces
// Valid/ready channels for YUYV groups in, RGB888 pixel pairs out, and the
// register write port.
// ----------------------------------------------------------------------------
interface yrgb_pix_in_if;
	import yrgb_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] luma_first;
	logic [PIX_W-1:0] chroma_blue;
	logic [PIX_W-1:0] luma_second;
	logic [PIX_W-1:0] chroma_red;
	logic             frame_end_in;

	modport source (
		output valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		input  ready
	);
	modport sink (
		input  valid, luma_first, chroma_blue, luma_second, chroma_red, frame_end_in,
		output ready
	);
endinterface

interface yrgb_pix_out_if;
	import yrgb_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] red_first;
	logic [PIX_W-1:0] green_first;
	logic [PIX_W-1:0] blue_first;
	logic [PIX_W-1:0] red_second;
	logic [PIX_W-1:0] green_second;
	logic [PIX_W-1:0] blue_second;
	logic             frame_end_out;

	modport source (
		output valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		input  ready
	);
	modport sink (
		input  valid, red_first, green_first, blue_first,
		       red_second, green_second, blue_second, frame_end_out,
		output ready
	);
endinterface

interface yrgb_cfg_if;
	import yrgb_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/yuyv_to_rgb888_adjust.sv =====
// ----------------------------------------------------------------------------
// yuyv_to_rgb888_adjust
// Full-range BT.601 YUYV 4:2:2 to RGB888 converter with per-channel offsets.
//
// pix_in takes one packed group (Y0 U Y1 V plus frame-end flag) per beat;
// pix_out gives the two RGB888 pixels of that group, which share the chroma,
// with the frame-end flag copied. Both are valid/ready channels.
// cfg writes the offset and Q-format coefficient registers; it is always
// ready, and registers should only be written while no beat is in flight.
// Three registered stages lie between an accepted input beat and its output
// beat (multiply, round and shift, add and saturate), and one beat is accepted
// every cycle while the receiver keeps up.
// When the receiver stalls, the output stage holds its beat and the stages
// behind it keep filling; input stalls only once all three stages are full.
// Reset empties the pipeline and loads the default BT.601 coefficients with
// zero offsets.
// ----------------------------------------------------------------------------
module yuyv_to_rgb888_adjust #(
	parameter int COEF_FRAC_BITS = yrgb_pkg::DEF_COEF_FRAC_BITS
) (
	input logic            clk,
	input logic            arst_n,
	yrgb_pix_in_if.sink    pix_in,
	yrgb_pix_out_if.source pix_out,
	yrgb_cfg_if.sink       cfg
);
	import yrgb_pkg::*;

	cfg_regs_t regs;
	yuyv_t     in_data;
	prod_t     prod_data;
	term_t     term_data;
	rgb_pair_t out_data;
	logic      prod_valid;
	logic      prod_ready;
	logic      term_valid;
	logic      term_ready;

	assign in_data.luma_first  = pix_in.luma_first;
	assign in_data.chroma_blue = pix_in.chroma_blue;
	assign in_data.luma_second = pix_in.luma_second;
	assign in_data.chroma_red  = pix_in.chroma_red;
	assign in_data.frame_end   = pix_in.frame_end_in;

	yrgb_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	yrgb_mult_stage u_mult_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (pix_in.valid),
		.up_ready (pix_in.ready),
		.up_data  (in_data),
		.regs     (regs),
		.dn_valid (prod_valid),
		.dn_ready (prod_ready),
		.dn_data  (prod_data)
	);

	yrgb_round_stage #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_round_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (prod_valid),
		.up_ready (prod_ready),
		.up_data  (prod_data),
		.dn_valid (term_valid),
		.dn_ready (term_ready),
		.dn_data  (term_data)
	);

	yrgb_clamp_stage u_clamp_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (term_valid),
		.up_ready (term_ready),
		.up_data  (term_data),
		.regs     (regs),
		.dn_valid (pix_out.valid),
		.dn_ready (pix_out.ready),
		.dn_data  (out_data)
	);

	assign pix_out.red_first     = out_data.red_first;
	assign pix_out.green_first   = out_data.green_first;
	assign pix_out.blue_first    = out_data.blue_first;
	assign pix_out.red_second    = out_data.red_second;
	assign pix_out.green_second  = out_data.green_second;
	assign pix_out.blue_second   = out_data.blue_second;
	assign pix_out.frame_end_out = out_data.frame_end;

	// input back-pressure only when every stage is full and the output is stalled
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> pix_out.valid && !pix_out.ready)
		else $error("input stalled while the pipeline has room");

	// an accepted beat reaches the output when the receiver keeps up
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		pix_in.valid && pix_in.ready ##1 pix_out.ready ##1 pix_out.ready |=> pix_out.valid)
		else $error("accepted beat did not reach the output in time");

	// a write to the V-to-R coefficient lands in its register
	a_coef_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready && cfg.index == REG_COEF_V_TO_R
		|=> regs.coef_v_to_r == $past(cfg.data[COEF_W-1:0]))
		else $error("coefficient write lost");

endmodule

// ===== design/yrgb_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// yrgb_cfg_regs
// Offset and coefficient registers, written one beat at a time.
// ----------------------------------------------------------------------------
module yrgb_cfg_regs (
	input  logic                clk,
	input  logic                arst_n,
	yrgb_cfg_if.sink            cfg,
	output yrgb_pkg::cfg_regs_t regs
);
	import yrgb_pkg::*;

	cfg_regs_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.offset_red   <= RST_OFFSET;
			regs_q.offset_green <= RST_OFFSET;
			regs_q.offset_blue  <= RST_OFFSET;
			regs_q.coef_v_to_r  <= RST_COEF_V_TO_R;
			regs_q.coef_u_to_g  <= RST_COEF_U_TO_G;
			regs_q.coef_v_to_g  <= RST_COEF_V_TO_G;
			regs_q.coef_u_to_b  <= RST_COEF_U_TO_B;
		end else if (cfg.valid) begin
			unique case (cfg_idx_t'(cfg.index))
				REG_OFFSET_RED:   regs_q.offset_red   <= cfg.data[OFFSET_W-1:0];
				REG_OFFSET_GREEN: regs_q.offset_green <= cfg.data[OFFSET_W-1:0];
				REG_OFFSET_BLUE:  regs_q.offset_blue  <= cfg.data[OFFSET_W-1:0];
				REG_COEF_V_TO_R:  regs_q.coef_v_to_r  <= cfg.data[COEF_W-1:0];
				REG_COEF_U_TO_G:  regs_q.coef_u_to_g  <= cfg.data[COEF_W-1:0];
				REG_COEF_V_TO_G:  regs_q.coef_v_to_g  <= cfg.data[COEF_W-1:0];
				REG_COEF_U_TO_B:  regs_q.coef_u_to_b  <= cfg.data[COEF_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== design/yrgb_mult_stage.sv =====
// ----------------------------------------------------------------------------
// yrgb_mult_stage
// First stage: centre the chroma samples and form the four coefficient
// products.
// ----------------------------------------------------------------------------
module yrgb_mult_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  yrgb_pkg::yuyv_t     up_data,
	input  yrgb_pkg::cfg_regs_t regs,
	output logic                dn_valid,
	input  logic                dn_ready,
	output yrgb_pkg::prod_t     dn_data
);
	import yrgb_pkg::*;

	logic                       valid_s1;
	prod_t                      data_s1;
	logic signed [CHROMA_W-1:0] du;
	logic signed [CHROMA_W-1:0] dv;

	assign du = $signed({1'b0, up_data.chroma_blue}) - $signed({1'b0, CHROMA_MID});
	assign dv = $signed({1'b0, up_data.chroma_red}) - $signed({1'b0, CHROMA_MID});

	assign up_ready = !valid_s1 || dn_ready;
	assign dn_valid = valid_s1;
	assign dn_data  = data_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s1.luma_first  <= up_data.luma_first;
			data_s1.luma_second <= up_data.luma_second;
			data_s1.frame_end   <= up_data.frame_end;
			data_s1.prod_v_to_r <= PROD_W'($signed({1'b0, regs.coef_v_to_r})) * PROD_W'(dv);
			data_s1.prod_u_to_g <= PROD_W'($signed({1'b0, regs.coef_u_to_g})) * PROD_W'(du);
			data_s1.prod_v_to_g <= PROD_W'($signed({1'b0, regs.coef_v_to_g})) * PROD_W'(dv);
			data_s1.prod_u_to_b <= PROD_W'($signed({1'b0, regs.coef_u_to_b})) * PROD_W'(du);
		end
	end

endmodule

// ===== design/yrgb_round_stage.sv =====
// ----------------------------------------------------------------------------
// yrgb_round_stage
// Second stage: sum the green products, add the rounding half and shift each
// chroma term down to integer pixel units.
// ----------------------------------------------------------------------------
module yrgb_round_stage #(
	parameter int COEF_FRAC_BITS = yrgb_pkg::DEF_COEF_FRAC_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            up_valid,
	output logic            up_ready,
	input  yrgb_pkg::prod_t up_data,
	output logic            dn_valid,
	input  logic            dn_ready,
	output yrgb_pkg::term_t dn_data
);
	import yrgb_pkg::*;

	localparam logic signed [SUM_W-1:0] HALF = SUM_W'(1) <<< (COEF_FRAC_BITS - 1);

	logic                    valid_s2;
	term_t                   data_s2;
	logic signed [SUM_W-1:0] red_sum;
	logic signed [SUM_W-1:0] green_sum;
	logic signed [SUM_W-1:0] blue_sum;

	assign red_sum   = SUM_W'(up_data.prod_v_to_r) + HALF;
	assign green_sum = HALF - SUM_W'(up_data.prod_u_to_g) - SUM_W'(up_data.prod_v_to_g);
	assign blue_sum  = SUM_W'(up_data.prod_u_to_b) + HALF;

	assign up_ready = !valid_s2 || dn_ready;
	assign dn_valid = valid_s2;
	assign dn_data  = data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s2.luma_first  <= up_data.luma_first;
			data_s2.luma_second <= up_data.luma_second;
			data_s2.frame_end   <= up_data.frame_end;
			data_s2.term_red    <= red_sum >>> COEF_FRAC_BITS;
			data_s2.term_green  <= green_sum >>> COEF_FRAC_BITS;
			data_s2.term_blue   <= blue_sum >>> COEF_FRAC_BITS;
		end
	end

endmodule

// ===== design/yrgb_clamp_stage.sv =====
// ----------------------------------------------------------------------------
// yrgb_clamp_stage
// Third stage: add luma and channel offset to each term, saturate to 8 bits
// and hold the result beat for the receiver.
// ----------------------------------------------------------------------------
module yrgb_clamp_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                up_valid,
	output logic                up_ready,
	input  yrgb_pkg::term_t     up_data,
	input  yrgb_pkg::cfg_regs_t regs,
	output logic                dn_valid,
	input  logic                dn_ready,
	output yrgb_pkg::rgb_pair_t dn_data
);
	import yrgb_pkg::*;

	logic      valid_s3;
	rgb_pair_t data_s3;

	function automatic logic [PIX_W-1:0] pix_clamp(
		input logic [PIX_W-1:0]         luma,
		input logic signed [SUM_W-1:0]  term,
		input logic signed [OFFSET_W-1:0] offset
	);
		logic signed [PIX_SUM_W-1:0] total;
		total = $signed(PIX_SUM_W'({1'b0, luma})) + PIX_SUM_W'(term) + PIX_SUM_W'(offset);
		if (total[PIX_SUM_W-1]) begin
			return '0;
		end else if (total > $signed(PIX_SUM_W'(PIX_MAX))) begin
			return PIX_MAX;
		end else begin
			return total[PIX_W-1:0];
		end
	endfunction

	assign up_ready = !valid_s3 || dn_ready;
	assign dn_valid = valid_s3;
	assign dn_data  = data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (up_ready) begin
			valid_s3 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			data_s3.red_first    <= pix_clamp(up_data.luma_first, up_data.term_red,
				regs.offset_red);
			data_s3.green_first  <= pix_clamp(up_data.luma_first, up_data.term_green,
				regs.offset_green);
			data_s3.blue_first   <= pix_clamp(up_data.luma_first, up_data.term_blue,
				regs.offset_blue);
			data_s3.red_second   <= pix_clamp(up_data.luma_second, up_data.term_red,
				regs.offset_red);
			data_s3.green_second <= pix_clamp(up_data.luma_second, up_data.term_green,
				regs.offset_green);
			data_s3.blue_second  <= pix_clamp(up_data.luma_second, up_data.term_blue,
				regs.offset_blue);
			data_s3.frame_end    <= up_data.frame_end;
		end
	end

endmodule
